// ===== hw/rtl/keyword_posterior_smoother_defines.svh =====
// ----------------------------------------------------------------------------
// keyword posterior smoother assertion macros
// concurrent assertion shorthands clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef KEYWORD_POSTERIOR_SMOOTHER_DEFINES_SVH
`define KEYWORD_POSTERIOR_SMOOTHER_DEFINES_SVH

// same-cycle implication
`define KPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// shared types, constants and square functions of the posterior smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kps_pkg;

  localparam int MaxKeywords = 4;
  localparam int Rows        = MaxKeywords + 1;
  localparam int WindowDepth = 8;
  localparam int ScoreW      = 8;
  localparam int SqW         = 17;
  localparam int SumW        = 20;
  localparam int ThW         = 20;
  localparam int WlW         = 4;
  localparam int KcW         = 3;
  localparam int HoW         = 8;
  localparam int FsrW        = 9;
  localparam int ClassW      = 3;
  localparam int AddrW       = 5;
  localparam int DataW       = 32;

  localparam logic [ThW-1:0]  GateThReset   = ThW'(20000);
  localparam logic [ThW-1:0]  DetectThReset = ThW'(20000);
  localparam logic [WlW-1:0]  WindowReset   = WlW'(8);
  localparam logic [KcW-1:0]  KwCountReset  = KcW'(2);
  localparam logic [HoW-1:0]  HoldoffReset  = HoW'(30);
  localparam logic [FsrW-1:0] FsrMax        = {FsrW{1'b1}};

  typedef enum logic [2:0] {
    REG_GATE_TH    = 3'd0,
    REG_DETECT_TH  = 3'd1,
    REG_WINDOW_LEN = 3'd2,
    REG_KW_COUNT   = 3'd3,
    REG_HOLDOFF    = 3'd4
  } reg_idx_t;

  typedef logic [SqW-1:0]  sq_t;
  typedef logic [SumW-1:0] sum_t;
  typedef logic [Rows-1:0][SqW-1:0] hist_word_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] noise_score;
    logic signed [ScoreW-1:0] kw_score_0;
    logic signed [ScoreW-1:0] kw_score_1;
    logic signed [ScoreW-1:0] kw_score_2;
    logic signed [ScoreW-1:0] kw_score_3;
  } frame_t;

  typedef struct packed {
    logic [ClassW-1:0] detected_class;
    logic [SumW-1:0]   gate_sum;
    logic              gate_open;
  } result_t;

  typedef struct packed {
    logic [ThW-1:0] gate_threshold;
    logic [ThW-1:0] detect_threshold;
    logic [WlW-1:0] window_length;
    logic [KcW-1:0] keyword_count;
    logic [HoW-1:0] holdoff_frames;
  } cfg_t;

  // s + 128 as unsigned
  function automatic logic [ScoreW-1:0] offset_score(input logic [ScoreW-1:0] raw);
    offset_score = raw ^ {1'b1, {(ScoreW-1){1'b0}}};
  endfunction

  function automatic sq_t kw_square(input logic [ScoreW-1:0] raw);
    logic [ScoreW-1:0]   v;
    logic [2*ScoreW-1:0] p;
    v = offset_score(raw);
    p = v * v;
    kw_square = SqW'(p);
  endfunction

  // (128 - s)^2
  function automatic sq_t noise_square(input logic [ScoreW-1:0] raw);
    logic [ScoreW:0]       w;
    logic [2*ScoreW+1:0]   p;
    w = {1'b1, {ScoreW{1'b0}}} - {1'b0, offset_score(raw)};
    p = w * w;
    noise_square = p[SqW-1:0];
  endfunction

endpackage

// ===== hw/rtl/kps_if.sv =====
// ----------------------------------------------------------------------------
// kps stream interfaces
// valid/ready channels for frame words and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kps_frame_if;
  logic            valid;
  logic            ready;
  kps_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kps_result_if;
  logic             valid;
  logic             ready;
  kps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/keyword_posterior_smoother.sv =====
// ----------------------------------------------------------------------------
// keyword_posterior_smoother
// smooths keyword classifier scores over a frame window and reports detections
// ----------------------------------------------------------------------------
// frame words (noise score and four keyword scores) come in on the frame
// channel, one result word per frame leaves on the result channel, both
// valid/ready. a frame is taken into an input register; its squares, window
// sums and decision are formed from that register and stored in the result
// register once that is empty or its word is being accepted, and the result
// word is presented from the result register.
// one frame per cycle is sustained unless the receiver stalls: the history
// ring, running sums and holdoff counter all update as a frame advances,
// with the oldest ring column prefetched into a register one frame ahead.
// while the receiver stalls the result register holds its word and one more
// frame waits in the input register; frame.ready drops only when both are full.
// reset empties both registers, loads the register defaults and clears the
// history and counters; there is no clearing pass. writing window_length over
// apb clears the history and window sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyword_posterior_smoother #(
  parameter int WINDOW_DEPTH = kps_pkg::WindowDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  kps_frame_if.sink                 frame,
  kps_result_if.source              result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kps_pkg::AddrW-1:0] paddr,
  input  logic [kps_pkg::DataW-1:0] pwdata,
  output logic [kps_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  kps_pkg::cfg_t       cfg;
  logic                clear;
  kps_pkg::frame_t     fr_q;
  logic                fr_vld;
  kps_pkg::result_t    res_q;
  logic                res_vld;
  logic                advance;
  kps_pkg::hist_word_t sq;
  kps_pkg::sum_t       sum_next [kps_pkg::Rows];
  kps_pkg::result_t    res_next;

  assign advance      = fr_vld && (!res_vld || result.ready);
  assign frame.ready  = !fr_vld || advance;
  assign result.valid = res_vld;
  assign result.data  = res_q;

  always_comb begin
    sq[0]                    = kps_pkg::kw_square(fr_q.kw_score_0);
    sq[1]                    = kps_pkg::kw_square(fr_q.kw_score_1);
    sq[2]                    = kps_pkg::kw_square(fr_q.kw_score_2);
    sq[3]                    = kps_pkg::kw_square(fr_q.kw_score_3);
    sq[kps_pkg::MaxKeywords] = kps_pkg::noise_square(fr_q.noise_score);
  end

  kps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (clear)
  );

  kps_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .clear         (clear),
    .step          (advance),
    .window_length (cfg.window_length),
    .sq_in         (sq),
    .sum_next      (sum_next)
  );

  kps_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .sums (sum_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_vld  <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      if (frame.valid && frame.ready) begin
        fr_vld <= 1'b1;
      end else if (advance) begin
        fr_vld <= 1'b0;
      end
      if (advance) begin
        res_vld <= 1'b1;
      end else if (result.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      fr_q <= frame.data;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

endmodule

// ===== hw/rtl/kps_cfg.sv =====
// ----------------------------------------------------------------------------
// kps_cfg
// apb register file; a window_length write raises the history clear pulse
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kps_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kps_pkg::AddrW-1:0]  paddr,
  input  logic [kps_pkg::DataW-1:0]  pwdata,
  output logic [kps_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output kps_pkg::cfg_t              cfg,
  output logic                       clear
);

  logic              wr_en;
  kps_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = kps_pkg::reg_idx_t'(paddr[kps_pkg::AddrW-1:2]);
  assign clear  = wr_en && (idx == kps_pkg::REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_threshold   <= kps_pkg::GateThReset;
      cfg.detect_threshold <= kps_pkg::DetectThReset;
      cfg.window_length    <= kps_pkg::WindowReset;
      cfg.keyword_count    <= kps_pkg::KwCountReset;
      cfg.holdoff_frames   <= kps_pkg::HoldoffReset;
    end else if (wr_en) begin
      case (idx)
        kps_pkg::REG_GATE_TH:    cfg.gate_threshold   <= pwdata[kps_pkg::ThW-1:0];
        kps_pkg::REG_DETECT_TH:  cfg.detect_threshold <= pwdata[kps_pkg::ThW-1:0];
        kps_pkg::REG_WINDOW_LEN: cfg.window_length    <= pwdata[kps_pkg::WlW-1:0];
        kps_pkg::REG_KW_COUNT:   cfg.keyword_count    <= pwdata[kps_pkg::KcW-1:0];
        kps_pkg::REG_HOLDOFF:    cfg.holdoff_frames   <= pwdata[kps_pkg::HoW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kps_pkg::REG_GATE_TH:    prdata = kps_pkg::DataW'(cfg.gate_threshold);
      kps_pkg::REG_DETECT_TH:  prdata = kps_pkg::DataW'(cfg.detect_threshold);
      kps_pkg::REG_WINDOW_LEN: prdata = kps_pkg::DataW'(cfg.window_length);
      kps_pkg::REG_KW_COUNT:   prdata = kps_pkg::DataW'(cfg.keyword_count);
      kps_pkg::REG_HOLDOFF:    prdata = kps_pkg::DataW'(cfg.holdoff_frames);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/kps_window.sv =====
// ----------------------------------------------------------------------------
// kps_window
// square history ring with prefetched oldest column and running window sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kps_window #(
  parameter int DEPTH = kps_pkg::WindowDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 step,
  input  logic [kps_pkg::WlW-1:0] window_length,
  input  kps_pkg::hist_word_t  sq_in,
  output kps_pkg::sum_t        sum_next [kps_pkg::Rows]
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kps_pkg::hist_word_t mem [DEPTH];
  logic [DEPTH-1:0]    col_valid;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       pos_next;
  logic [CW-1:0]       eff_win;
  logic [CW-1:0]       pos_inc;
  kps_pkg::hist_word_t rd_q;
  logic                rd_vld;
  kps_pkg::sum_t       sums [kps_pkg::Rows];

  always_comb begin
    if (window_length == '0) begin
      eff_win = CW'(1);
    end else if (int'(window_length) > DEPTH) begin
      eff_win = CW'(DEPTH);
    end else begin
      eff_win = CW'(window_length);
    end
    pos_inc  = CW'(pos) + CW'(1);
    pos_next = (pos_inc >= eff_win) ? '0 : IW'(pos_inc);
  end

  always_comb begin
    for (int r = 0; r < kps_pkg::Rows; r++) begin
      sum_next[r] = sums[r] - (rd_vld ? kps_pkg::SumW'(rd_q[r]) : '0)
                    + kps_pkg::SumW'(sq_in[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (step && !clear) begin
      mem[pos] <= sq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_valid <= '0;
      pos       <= '0;
      rd_vld    <= 1'b0;
      for (int r = 0; r < kps_pkg::Rows; r++) begin
        sums[r] <= '0;
      end
    end else if (step) begin
      col_valid[pos] <= 1'b1;
      pos            <= pos_next;
      sums           <= sum_next;
      // a one-frame window reads back the column just written
      if (pos_next == pos) begin
        rd_q   <= sq_in;
        rd_vld <= 1'b1;
      end else begin
        rd_q   <= mem[pos_next];
        rd_vld <= col_valid[pos_next];
      end
    end
  end

endmodule

// ===== hw/rtl/kps_decide.sv =====
// ----------------------------------------------------------------------------
// kps_decide
// gate compare, keyword arg-max over threshold and report holdoff counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kps_decide (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  kps_pkg::cfg_t    cfg,
  input  kps_pkg::sum_t    sums [kps_pkg::Rows],
  output kps_pkg::result_t res
);

  logic [kps_pkg::FsrW-1:0]   frames_since_report;
  logic [kps_pkg::FsrW-1:0]   fsr_inc;
  logic [kps_pkg::KcW-1:0]    kn;
  logic                       gate;
  logic                       found;
  logic                       fire;
  kps_pkg::sum_t              best_sum;
  logic [kps_pkg::ClassW-1:0] best_cls;

  always_comb begin
    kn = (int'(cfg.keyword_count) > kps_pkg::MaxKeywords)
         ? kps_pkg::KcW'(kps_pkg::MaxKeywords) : cfg.keyword_count;
    gate     = sums[kps_pkg::MaxKeywords] > cfg.gate_threshold;
    best_sum = cfg.detect_threshold;
    best_cls = '0;
    found    = 1'b0;
    for (int r = 0; r < kps_pkg::MaxKeywords; r++) begin
      if (gate && (r < int'(kn)) && (sums[r] > best_sum)) begin
        best_sum = sums[r];
        best_cls = kps_pkg::ClassW'(r + 1);
        found    = 1'b1;
      end
    end
    fsr_inc = (frames_since_report == kps_pkg::FsrMax)
              ? frames_since_report : frames_since_report + 1'b1;
    fire    = found && (fsr_inc > kps_pkg::FsrW'(cfg.holdoff_frames));

    res.detected_class = fire ? best_cls : '0;
    res.gate_sum       = sums[kps_pkg::MaxKeywords];
    res.gate_open      = gate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_since_report <= '0;
    end else if (step) begin
      frames_since_report <= fire ? '0 : fsr_inc;
    end
  end

endmodule

// ===== hw/rtl/kps_checker.sv =====
// ----------------------------------------------------------------------------
// kps_checker
// port-level checks of the posterior smoother, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyword_posterior_smoother_defines.svh"

module kps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       frame_valid,
  input logic                       frame_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [kps_pkg::ClassW-1:0] detected_class,
  input logic [kps_pkg::SumW-1:0]   gate_sum,
  input logic                       gate_open
);

  `KPS_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(detected_class) && $stable(gate_sum) && $stable(gate_open), "result word changed while stalled")

  `KPS_ASSERT_NXT(a_frame_to_result, (frame_valid && frame_ready) ##1 result_ready, result_valid, "taken frame gave no result")

  `KPS_ASSERT_IMP(a_detect_needs_gate, result_valid && (detected_class != '0), gate_open, "detection with gate closed")

  `KPS_ASSERT_IMP(a_class_range, result_valid, int'(detected_class) <= kps_pkg::MaxKeywords, "detected class out of range")

endmodule

bind keyword_posterior_smoother kps_checker u_kps_checker (
  .clk            (clk),
  .rst            (rst),
  .frame_valid    (frame.valid),
  .frame_ready    (frame.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .detected_class (result.data.detected_class),
  .gate_sum       (result.data.gate_sum),
  .gate_open      (result.data.gate_open)
);
